FILE: sv/price_level_order_book_macros.svh
// Assertion macros of the price level order book RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`ifndef ASSERT_OFF
`define POB_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("order book assertion failed");
`define POB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("order book assertion failed");
`else
`define POB_ASSERT(lbl, clk, rstn, prop)
`define POB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/pob_pkg.sv
// Shared types, sizes and request codes of the price level order book.
// No dependencies.
package pob_pkg;
	localparam int ORDER_SLOTS     = 4096;
	localparam int LEVELS_PER_SIDE = 256;
	localparam int LEVEL_SLOTS     = 2 * LEVELS_PER_SIDE;
	localparam int OA_W            = $clog2(ORDER_SLOTS);
	localparam int LA_W            = $clog2(LEVEL_SLOTS);
	localparam int CLEAR_DEPTH     = (ORDER_SLOTS > LEVEL_SLOTS) ? ORDER_SLOTS : LEVEL_SLOTS;
	localparam int CNT_W           = $clog2(CLEAR_DEPTH + 1);
	localparam int LCNT_W          = $clog2(ORDER_SLOTS + 1);

	localparam logic [2:0] REQ_INSERT  = 3'd0;
	localparam logic [2:0] REQ_REMOVE  = 3'd1;
	localparam logic [2:0] REQ_SET_REM = 3'd2;
	localparam logic [2:0] REQ_AMEND   = 3'd3;
	localparam logic [2:0] REQ_TRADE   = 3'd4;
	localparam logic [2:0] REQ_QUERY   = 3'd5;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [11:0] slot_id;
		logic        side;
		logic [30:0] price;
		logic [30:0] quantity;
		logic        is_market;
	} pob_req_t;

	typedef struct packed {
		logic               ok;
		logic [30:0]        top_bid;
		logic [30:0]        top_ask;
		logic [47:0]        top_bid_qty;
		logic [47:0]        top_ask_qty;
		logic signed [31:0] spread;
		logic [30:0]        mid_px;
		logic [47:0]        crossable_qty;
		logic               crosses;
	} pob_res_t;

	typedef struct packed {
		logic        live;
		logic        side;
		logic [30:0] price;
		logic [30:0] rem;
	} pob_ord_t;

	typedef struct packed {
		logic              valid;
		logic [30:0]       price;
		logic [47:0]       total;
		logic [LCNT_W-1:0] count;
	} pob_lvl_t;

	localparam int ORD_W = $bits(pob_ord_t);
	localparam int LVL_W = $bits(pob_lvl_t);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_ORD_WAIT, ST_FIND, ST_DET_WR,
		ST_ATT_WR, ST_LVL_WR, ST_BEST, ST_DONE
	} pob_state_t;

	typedef enum logic [1:0] {ACT_DETACH, ACT_ATTACH, ACT_UPDATE} pob_act_t;
endpackage

FILE: sv/price_level_order_book.sv
// Top level of the price level order book: request intake and result register.
// Depends on pob_pkg and pob_engine.
//
// Usage: requests arrive on req (valid/stall), one result leaves on rsp per request.
// A beat is taken when valid is high and stall low. One request is worked at a time:
// req_stall is high from the accepted beat until the result has moved into the
// result register. A request reads its order slot, then runs level searches over one
// side (none for query or rejected requests, one for insert, remove, set remaining
// and trade, two for amend unless its new price or quantity is zero), one write per
// search and the top-of-book scan over all 512 level slots. After reset the block
// clears its order and level memories, one entry per cycle, with req_stall held
// high. The result register holds a beat while rsp_stall is high; the next request
// is taken meanwhile and waits finished inside the engine until the register frees.
module price_level_order_book import pob_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  pob_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output pob_res_t rsp
);
	logic     eng_idle, eng_valid, res_take;
	pob_res_t eng_res;

	pob_engine u_engine (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req(req),
		.idle(eng_idle), .res_valid(eng_valid), .res(eng_res), .res_take(res_take)
	);

	assign req_stall = !eng_idle;
	assign res_take  = !rsp_valid || !rsp_stall;

	// Result register: loads when empty or when its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (res_take) begin
			rsp_valid <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && eng_valid) begin
			rsp <= eng_res;
		end
	end
endmodule

FILE: sv/pob_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pob_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/pob_engine.sv
// Request sequencer of the order book: order and level memories, level scans.
// Depends on pob_pkg, pob_ram and the assertion macro header.
`include "price_level_order_book_macros.svh"
module pob_engine import pob_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  pob_req_t req,
	output logic     idle,
	output logic     res_valid,
	output pob_res_t res,
	input  logic     res_take
);
	pob_state_t state_q, state_d;
	pob_act_t   act_q;
	pob_req_t   req_q;
	pob_ord_t   ord_ent_q, od;
	pob_lvl_t   hit_ent_q, le, lvl_new;
	logic       amend_q, ok_q;
	logic       att_side_q, find_side_q;
	logic [30:0] att_price_q, att_rem_q, find_price_q;
	logic [CNT_W-1:0] cnt_q;
	logic       scan_v_s1;
	logic [LA_W-1:0] scan_idx_s1;
	logic       hit_q, free_q;
	logic [LA_W-1:0] hit_idx_q, free_idx_q;
	logic       bb_found_q, ba_found_q;
	logic [30:0] bb_q, ba_q;
	logic [47:0] bbq_q, baq_q, cq_q;

	logic ord_we, lvl_we, scan_issue, scan_done, start_scan;
	logic [OA_W-1:0] ord_waddr, ord_raddr;
	logic [LA_W-1:0] lvl_waddr, lvl_raddr, find_base;
	logic [ORD_W-1:0] ord_wdata, ord_rdata;
	logic [LVL_W-1:0] lvl_wdata, lvl_rdata;
	logic live, idok, start_ok, lim_ok, in_opp;
	logic [30:0] limit;
	logic [47:0] sub_a, sub_b, sub_r;
	logic both;
	logic [31:0] pair_sum;

	pob_ram #(.W(ORD_W), .D(ORDER_SLOTS)) u_ord_ram (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	pob_ram #(.W(LVL_W), .D(LEVEL_SLOTS)) u_lvl_ram (
		.clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
		.raddr(lvl_raddr), .rdata(lvl_rdata)
	);

	assign od   = pob_ord_t'(ord_rdata);
	assign le   = pob_lvl_t'(lvl_rdata);
	assign idok = (32'(req_q.slot_id) < ORDER_SLOTS);
	assign live = idok && od.live;
	assign find_base = find_side_q ? LA_W'(LEVELS_PER_SIDE) : '0;

	// Scan progress: one level read issued per cycle, its data in the cycle after.
	assign scan_issue = ((state_q == ST_FIND) && (cnt_q < CNT_W'(LEVELS_PER_SIDE))) ||
		((state_q == ST_BEST) && (cnt_q < CNT_W'(LEVEL_SLOTS)));
	assign scan_done  = !scan_issue && !scan_v_s1;
	assign start_scan = (state_d != state_q) && ((state_d == ST_FIND) || (state_d == ST_BEST));

	// Which request starts a level search once the order entry is read.
	always_comb begin
		case (req_q.req_type)
			REQ_INSERT: start_ok = idok && !live && (req_q.price != '0) && (req_q.quantity != '0);
			REQ_REMOVE, REQ_SET_REM, REQ_AMEND, REQ_TRADE: start_ok = live;
			default: start_ok = 1'b0;
		endcase
	end

	// Shared saturating subtract used by detach, set remaining and trade.
	always_comb begin
		sub_a = hit_ent_q.total;
		sub_b = (act_q == ACT_UPDATE && req_q.req_type == REQ_TRADE) ?
			48'(req_q.quantity) : 48'(ord_ent_q.rem);
		sub_r = (sub_a >= sub_b) ? sub_a - sub_b : '0;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (cnt_q == CNT_W'(CLEAR_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (req_valid) state_d = ST_ORD_WAIT;
			ST_ORD_WAIT: state_d = start_ok ? ST_FIND : ST_BEST;
			ST_FIND: begin
				if (scan_done) begin
					case (act_q)
						ACT_DETACH: state_d = ST_DET_WR;
						ACT_ATTACH: state_d = ST_ATT_WR;
						default: state_d = ST_LVL_WR;
					endcase
				end
			end
			ST_DET_WR: state_d = (amend_q && req_q.price != '0 && req_q.quantity != '0) ?
				ST_FIND : ST_BEST;
			ST_ATT_WR, ST_LVL_WR: state_d = ST_BEST;
			ST_BEST: if (scan_done) state_d = ST_DONE;
			ST_DONE: if (res_take) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls and outputs.
	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = req_q.slot_id[OA_W-1:0];
		ord_wdata = ORD_W'(ord_ent_q);
		ord_raddr = req.slot_id[OA_W-1:0];
		lvl_we    = 1'b0;
		lvl_waddr = hit_idx_q;
		lvl_new   = hit_ent_q;
		lvl_raddr = (state_q == ST_FIND) ? LA_W'(find_base + cnt_q[LA_W-1:0]) : cnt_q[LA_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				ord_we    = (cnt_q < CNT_W'(ORDER_SLOTS));
				ord_waddr = cnt_q[OA_W-1:0];
				ord_wdata = '0;
				lvl_we    = (cnt_q < CNT_W'(LEVEL_SLOTS));
				lvl_waddr = cnt_q[LA_W-1:0];
				lvl_new   = '0;
			end
			ST_DET_WR: begin
				ord_we = 1'b1;
				ord_wdata = ORD_W'({1'b0, ord_ent_q.side, ord_ent_q.price, ord_ent_q.rem});
				lvl_we = hit_q;
				lvl_new.total = sub_r;
				lvl_new.count = (hit_ent_q.count != '0) ? hit_ent_q.count - 1'b1 : '0;
				lvl_new.valid = (lvl_new.count != '0);
			end
			ST_ATT_WR: begin
				ord_we    = hit_q || free_q;
				ord_wdata = ORD_W'({1'b1, att_side_q, att_price_q, att_rem_q});
				lvl_we    = hit_q || free_q;
				lvl_waddr = hit_q ? hit_idx_q : free_idx_q;
				lvl_new.valid = 1'b1;
				lvl_new.price = att_price_q;
				lvl_new.total = (hit_q ? hit_ent_q.total : 48'd0) + 48'(att_rem_q);
				lvl_new.count = (hit_q ? hit_ent_q.count : '0) + 1'b1;
			end
			ST_LVL_WR: begin
				if (req_q.req_type == REQ_SET_REM) begin
					ord_we    = 1'b1;
					ord_wdata = ORD_W'({ord_ent_q.live, ord_ent_q.side, ord_ent_q.price,
						req_q.quantity});
					lvl_we    = hit_q;
					lvl_new.total = sub_r + 48'(req_q.quantity);
				end else begin
					lvl_we    = hit_q && (req_q.quantity != '0);
					lvl_new.total = sub_r;
				end
			end
			default: ;
		endcase
		lvl_wdata = LVL_W'(lvl_new);

		both     = (bb_q != '0) && (ba_q != '0);
		pair_sum = {1'b0, bb_q} + {1'b0, ba_q};
		res_valid = (state_q == ST_DONE);
		idle      = (state_q == ST_IDLE);
		res.ok            = ok_q;
		res.top_bid       = bb_q;
		res.top_ask       = ba_q;
		res.top_bid_qty   = bbq_q;
		res.top_ask_qty   = baq_q;
		res.spread        = both ? $signed({1'b0, ba_q} - {1'b0, bb_q}) : '0;
		res.mid_px        = both ? pair_sum[31:1] : '0;
		res.crossable_qty = cq_q;
		res.crosses       = (req_q.side == 1'b0) ? ((ba_q != '0) && (req_q.price >= ba_q)) :
			((bb_q != '0) && (req_q.price <= bb_q));
	end

	// Query limit and opposite-half test for the crossable sum.
	assign limit  = req_q.is_market ? '0 : req_q.price;
	assign in_opp = req_q.side ? (scan_idx_s1 < LA_W'(LEVELS_PER_SIDE)) :
		(scan_idx_s1 >= LA_W'(LEVELS_PER_SIDE));
	assign lim_ok = (limit == '0) || (req_q.side ? (le.price >= limit) : (le.price <= limit));

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= scan_issue;
			if (start_scan) begin
				cnt_q <= '0;
			end else if (state_q == ST_CLEAR || scan_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Request, search and top-of-book registers.
	always_ff @(posedge clk) begin
		scan_idx_s1 <= lvl_raddr;
		if (state_q == ST_IDLE && req_valid) begin
			req_q   <= req;
			ok_q    <= 1'b0;
			amend_q <= 1'b0;
		end
		if (state_q == ST_ORD_WAIT) begin
			ord_ent_q <= od;
			ok_q      <= (req_q.req_type == REQ_QUERY) ||
				(start_ok && req_q.req_type != REQ_INSERT && req_q.req_type != REQ_AMEND);
			amend_q   <= (req_q.req_type == REQ_AMEND);
			att_side_q  <= (req_q.req_type == REQ_INSERT) ? req_q.side : od.side;
			att_price_q <= req_q.price;
			att_rem_q   <= (req_q.req_type == REQ_INSERT) ? req_q.quantity : od.rem;
			if (req_q.req_type == REQ_INSERT) begin
				find_side_q  <= req_q.side;
				find_price_q <= req_q.price;
				act_q        <= ACT_ATTACH;
			end else begin
				find_side_q  <= od.side;
				find_price_q <= od.price;
				act_q        <= (req_q.req_type == REQ_SET_REM || req_q.req_type == REQ_TRADE) ?
					ACT_UPDATE : ACT_DETACH;
			end
		end
		if (state_q == ST_DET_WR) begin
			find_side_q  <= att_side_q;
			find_price_q <= att_price_q;
			act_q        <= ACT_ATTACH;
		end
		if (state_q == ST_ATT_WR) begin
			ok_q <= hit_q || free_q;
		end
		if (start_scan) begin
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			bb_found_q <= 1'b0;
			ba_found_q <= 1'b0;
			bb_q  <= '0;
			ba_q  <= '0;
			bbq_q <= '0;
			baq_q <= '0;
			cq_q  <= '0;
		end else if (scan_v_s1 && state_q == ST_FIND) begin
			if (le.valid && le.price == find_price_q && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= scan_idx_s1;
				hit_ent_q <= le;
			end
			if (!le.valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= scan_idx_s1;
			end
		end else if (scan_v_s1 && state_q == ST_BEST && le.valid) begin
			if (scan_idx_s1 < LA_W'(LEVELS_PER_SIDE)) begin
				if (!bb_found_q || le.price > bb_q) begin
					bb_found_q <= 1'b1;
					bb_q  <= le.price;
					bbq_q <= le.total;
				end
			end else if (!ba_found_q || le.price < ba_q) begin
				ba_found_q <= 1'b1;
				ba_q  <= le.price;
				baq_q <= le.total;
			end
			if (req_q.req_type == REQ_QUERY && in_opp && le.total != '0 && lim_ok) begin
				cq_q <= cq_q + le.total;
			end
		end
	end

	`POB_ASSERT_IMP(a_idle_no_write, clk, arst_n, state_q == ST_IDLE, !ord_we && !lvl_we)
	`POB_ASSERT_IMP(a_write_not_during_scan, clk, arst_n, lvl_we, !scan_issue && !scan_v_s1)
	`POB_ASSERT_IMP(a_scan_data_in_scan, clk, arst_n, scan_v_s1,
		state_q == ST_FIND || state_q == ST_BEST)
endmodule
